>>> hdl/rrma_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the residue modular ALU pipeline.
// No dependencies; used by every module of the block except rrma_rem_stage.
package rrma_pkg;

	// Width of the second operand field (residue or plain integer)
	localparam int OPB_BITS = 31;

	// Remainder steps (one dividend bit each) folded into one pipeline stage
	localparam int STEPS_PER_STAGE = 2;

	// Operation selector carried in tuser
	typedef enum logic [2:0] {
		KIND_ADD  = 3'd0,
		KIND_SUB  = 3'd1,
		KIND_MUL  = 3'd2,
		KIND_DEC  = 3'd3,
		KIND_SUBI = 3'd4,
		KIND_SET  = 3'd5
	} kind_t;

	// Control that travels with each item down the pipeline
	typedef struct packed {
		logic  valid;
		kind_t kind;
	} ctl_t;

endpackage

>>> hdl/rns_residue_modular_alu.sv
`timescale 1ns / 1ps
// Top level of one residue-number-system lane ALU: operand reduction,
// product/combine stage, product reduction, output skid. Uses rrma_pkg,
// rrma_rem_stage and rrma_combine.
//
//  channel | dir | fields (tdata low bit up)                  | tuser
//  s_*     | in  | residue_a, operand_b[30:0], modulus, zeros  | kind[2:0]
//  m_*     | out | result, zeros                              | -
//
// One item per cycle sustained while m_tready stays high. The pipeline is the
// operand remainder stages, the combine stage, the product remainder stages
// and the output register; the remainder chains are two-bits-per-stage restoring.
// Reset clears all valid bits and the output/skid flags; no clearing pass.
// A stall at m_* fills a one-item skid; s_tready then drops and the whole
// pipeline holds until the skid drains.
module rns_residue_modular_alu #(
	parameter int RESIDUE_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// residue_a, operand_b, modulus, zero pad
	input  logic [((2*RESIDUE_BITS+rrma_pkg::OPB_BITS+7)/8)*8-1:0] s_tdata,
	// kind
	input  logic [2:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// result, zero pad
	output logic [((RESIDUE_BITS+7)/8)*8-1:0] m_tdata
);

	localparam int R     = RESIDUE_BITS;
	localparam int OB    = rrma_pkg::OPB_BITS;
	localparam int K     = rrma_pkg::STEPS_PER_STAGE;
	localparam int D1    = (R > OB) ? R : OB;
	localparam int N1    = (D1 + K - 1) / K;
	localparam int T1    = N1 * K;
	localparam int N2    = (R + K - 1) / K;
	localparam int T2    = N2 * K;
	localparam int OUT_W = ((R + 7) / 8) * 8;

	logic en;

	// Operand reduction chain
	rrma_pkg::ctl_t ctl1 [0:N1];
	logic [R-1:0]   m1   [0:N1];
	logic [R-1:0]   ra1  [0:N1];
	logic [R-1:0]   rb1  [0:N1];
	logic [T1-1:0]  da1  [0:N1];
	logic [T1-1:0]  db1  [0:N1];

	// Middle stage outputs
	rrma_pkg::ctl_t ctl_c;
	logic [2*R-1:0] prod_c;
	logic [R-1:0]   side_c;
	logic [R-1:0]   m_c;

	// Product reduction chain
	rrma_pkg::ctl_t ctl2  [0:N2];
	logic [R-1:0]   m2    [0:N2];
	logic [R-1:0]   side2 [0:N2];
	logic [R-1:0]   r2    [0:N2];
	logic [T2-1:0]  d2    [0:N2];

	logic [R-1:0] fin_result;
	logic         push;
	logic         out_valid_q;
	logic         skid_valid_q;
	logic [R-1:0] out_data_q;
	logic [R-1:0] skid_data_q;

	// Whole pipeline advances while the skid is empty
	assign en       = !skid_valid_q;
	assign s_tready = en;

	// Unpack input item
	assign ctl1[0] = '{valid: s_tvalid, kind: rrma_pkg::kind_t'(s_tuser)};
	assign ra1[0]  = '0;
	assign rb1[0]  = '0;
	assign da1[0]  = T1'(s_tdata[R-1:0]);
	assign db1[0]  = T1'(s_tdata[R+OB-1:R]);
	assign m1[0]   = s_tdata[2*R+OB-1:R+OB];

	// Reduce residue_a and operand_b modulo the modulus
	for (genvar i = 0; i < N1; i++) begin : g_red1
		rrma_rem_stage #(.RW(R), .DW(T1), .NSTEP(K)) u_rem_a (
			.clk     (clk),
			.en      (en),
			.rem_in  (ra1[i]),
			.bits_in (da1[i]),
			.modulus (m1[i]),
			.rem_s1  (ra1[i+1]),
			.bits_s1 (da1[i+1])
		);
		rrma_rem_stage #(.RW(R), .DW(T1), .NSTEP(K)) u_rem_b (
			.clk     (clk),
			.en      (en),
			.rem_in  (rb1[i]),
			.bits_in (db1[i]),
			.modulus (m1[i]),
			.rem_s1  (rb1[i+1]),
			.bits_s1 (db1[i+1])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl1[i+1] <= '0;
			end else if (en) begin
				ctl1[i+1] <= ctl1[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				m1[i+1] <= m1[i];
			end
		end
	end

	// Product and non-multiply result
	rrma_combine #(.RW(R)) u_combine (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.ctl_in     (ctl1[N1]),
		.a          (ra1[N1]),
		.b          (rb1[N1]),
		.modulus    (m1[N1]),
		.ctl_s1     (ctl_c),
		.prod_s1    (prod_c),
		.side_s1    (side_c),
		.modulus_s1 (m_c)
	);

	// Product < m*m, so its bits above T2 already sit below the modulus
	assign ctl2[0]  = ctl_c;
	assign m2[0]    = m_c;
	assign side2[0] = side_c;
	assign r2[0]    = R'(prod_c[2*R-1:T2]);
	assign d2[0]    = prod_c[T2-1:0];

	// Reduce the product modulo the modulus
	for (genvar j = 0; j < N2; j++) begin : g_red2
		rrma_rem_stage #(.RW(R), .DW(T2), .NSTEP(K)) u_rem_p (
			.clk     (clk),
			.en      (en),
			.rem_in  (r2[j]),
			.bits_in (d2[j]),
			.modulus (m2[j]),
			.rem_s1  (r2[j+1]),
			.bits_s1 (d2[j+1])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl2[j+1] <= '0;
			end else if (en) begin
				ctl2[j+1] <= ctl2[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				m2[j+1]    <= m2[j];
				side2[j+1] <= side2[j];
			end
		end
	end

	// Final select; a zero modulus yields zero
	assign fin_result = (m2[N2] == '0) ? '0 :
		(ctl2[N2].kind == rrma_pkg::KIND_MUL) ? r2[N2] : side2[N2];
	assign push = en && ctl2[N2].valid;

	// Output register with one-item skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			out_data_q <= skid_valid_q ? skid_data_q : fin_result;
		end else if (push) begin
			skid_data_q <= fin_result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'(out_data_q);

endmodule

>>> hdl/rrma_rem_stage.sv
`timescale 1ns / 1ps
// One registered stage of a restoring remainder: shifts in NSTEP dividend
// bits, MSB first, and subtracts the modulus when the partial remainder reaches it.
module rrma_rem_stage #(
	parameter int RW    = 24,
	parameter int DW    = 32,
	parameter int NSTEP = 2
) (
	input  logic          clk,
	input  logic          en,
	input  logic [RW-1:0] rem_in,
	input  logic [DW-1:0] bits_in,
	input  logic [RW-1:0] modulus,
	output logic [RW-1:0] rem_s1,
	output logic [DW-1:0] bits_s1
);

	logic [RW-1:0] r_w;
	logic [RW:0]   t_w;
	logic [RW-1:0] rem_next;

	// Shift-in / conditional subtract; remainder stays below the modulus
	always_comb begin
		r_w = rem_in;
		t_w = '0;
		for (int s = 0; s < NSTEP; s++) begin
			t_w = {r_w, bits_in[DW-1-s]};
			if (t_w >= {1'b0, modulus}) begin
				t_w = t_w - {1'b0, modulus};
			end
			r_w = t_w[RW-1:0];
		end
		rem_next = r_w;
	end

	// Payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1  <= rem_next;
			bits_s1 <= bits_in << NSTEP;
		end
	end

endmodule

>>> hdl/rrma_combine.sv
`timescale 1ns / 1ps
// Middle stage: full-width product of the reduced operands, plus the
// add/subtract/set result that needs no further reduction. Uses rrma_pkg.
module rrma_combine #(
	parameter int RW = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  rrma_pkg::ctl_t  ctl_in,
	input  logic [RW-1:0]   a,
	input  logic [RW-1:0]   b,
	input  logic [RW-1:0]   modulus,
	output rrma_pkg::ctl_t  ctl_s1,
	output logic [2*RW-1:0] prod_s1,
	output logic [RW-1:0]   side_s1,
	output logic [RW-1:0]   modulus_s1
);

	localparam int PW = 2 * RW;

	logic          gt1;
	logic [RW-1:0] sub_b;
	logic [RW:0]   sum;
	logic [RW-1:0] sum_red;
	logic [RW-1:0] diff_wrap;
	logic [RW-1:0] diff;
	logic [RW-1:0] side;

	// Decrement subtracts 1 mod m, which is 0 when m is 1
	assign gt1   = (modulus > RW'(1));
	assign sub_b = (ctl_in.kind == rrma_pkg::KIND_DEC) ? RW'(gt1) : b;

	// Modular add: one conditional subtract
	assign sum     = {1'b0, a} + {1'b0, b};
	assign sum_red = (sum >= {1'b0, modulus}) ? RW'(sum - {1'b0, modulus}) : RW'(sum);

	// Modular subtract: add the modulus back on borrow
	assign diff_wrap = a - sub_b;
	assign diff      = (a >= sub_b) ? diff_wrap : diff_wrap + modulus;

	always_comb begin
		case (ctl_in.kind)
			rrma_pkg::KIND_ADD:  side = sum_red;
			rrma_pkg::KIND_SUB,
			rrma_pkg::KIND_DEC,
			rrma_pkg::KIND_SUBI: side = diff;
			rrma_pkg::KIND_SET:  side = b;
			default:             side = a;
		endcase
	end

	// Control register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1    <= PW'(a) * PW'(b);
			side_s1    <= side;
			modulus_s1 <= modulus;
		end
	end

endmodule

>>> hdl/rrma_chk.sv
`timescale 1ns / 1ps
// Port-level checker for rns_residue_modular_alu, attached by bind.
// Depends only on rrma_pkg and the top level's ports.
module rrma_chk #(
	parameter int RESIDUE_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic [((2*RESIDUE_BITS+rrma_pkg::OPB_BITS+7)/8)*8-1:0] s_tdata,
	input logic [2:0] s_tuser,
	input logic m_tvalid,
	input logic m_tready,
	input logic [((RESIDUE_BITS+7)/8)*8-1:0] m_tdata
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Input backpressure only while a result is waiting
	a_bp_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("s_tready low with no pending result");

	// Backpressure starts only after an output stall
	a_bp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(m_tvalid && !m_tready))
		else $error("s_tready fell without an output stall");

	// A free output keeps the input open
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready && m_tready |=> s_tready)
		else $error("s_tready dropped while output drained");

endmodule

bind rns_residue_modular_alu rrma_chk #(.RESIDUE_BITS(RESIDUE_BITS)) u_rrma_chk (.*);

>>> test/tb_rns_residue_modular_alu.sv
`timescale 1ns / 1ps
// Self-checking bench for rns_residue_modular_alu: directed corner items, then
// random residue operations under bursty input and random output backpressure.
// Depends on rrma_pkg and the RTL of the block only.
module tb_rns_residue_modular_alu;

	localparam int RB = 24;
	localparam int OPB_W = rrma_pkg::OPB_BITS;
	localparam int SDW = ((2*RB+OPB_W+7)/8)*8;
	localparam int MDW = ((RB+7)/8)*8;
	localparam int RANDOM_ITEMS = 1330;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 60;
	localparam logic [RB-1:0] RES_MAX = {RB{1'b1}};
	localparam logic [RB-1:0] BIG_PRIME = 24'd16777213;
	localparam logic [OPB_W-1:0] OPB_MAX = {OPB_W{1'b1}};
	// tuser codes with no operation behind them
	localparam logic [2:0] KIND_SPARE6 = 3'd6;
	localparam logic [2:0] KIND_SPARE7 = 3'd7;

	typedef struct {
		logic [2:0]       kind;
		logic [RB-1:0]    a;
		logic [OPB_W-1:0] b;
		logic [RB-1:0]    m;
		bit               drain;	// hold this item until all results are back
	} lane_op_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// residue_a, operand_b, modulus, zero pad
	logic [SDW-1:0] s_tdata = '0;
	// kind
	logic [2:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// result, zero pad
	logic [MDW-1:0] m_tdata;

	lane_op_t        ops_to_send[$];
	logic [RB-1:0]   predicted_residues[$];
	logic [RB-1:0]   driven_residue;
	int unsigned     items_sent = 0;
	int unsigned     results_seen = 0;
	int unsigned     error_count = 0;
	int unsigned     burst_left = 0;
	int unsigned     gap_left = 0;
	int unsigned     stall_mode = 0;
	int unsigned     mode_left = 0;
	int unsigned     stall_phase = 0;
	int unsigned     idle_cycles = 0;

	rns_residue_modular_alu #(.RESIDUE_BITS(RB)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Expected new residue of one lane operation
	function automatic logic [RB-1:0] lane_residue(lane_op_t op);
		longint unsigned a, b, m, one, r;
		m = op.m;
		if (m == 0)
			return '0;
		a = op.a % m;
		b = op.b % m;
		one = 1 % m;
		case (op.kind)
			rrma_pkg::KIND_ADD:  r = (a + b) % m;
			rrma_pkg::KIND_SUB,
			rrma_pkg::KIND_SUBI: r = (a >= b) ? a - b : a + m - b;
			rrma_pkg::KIND_MUL:  r = (a * b) % m;
			rrma_pkg::KIND_DEC:  r = (a >= one) ? a - one : a + m - one;
			rrma_pkg::KIND_SET:  r = b;
			default:             r = a;
		endcase
		return r[RB-1:0];
	endfunction

	task automatic push_op(logic [2:0] kind, logic [RB-1:0] a, logic [OPB_W-1:0] b,
			logic [RB-1:0] m, bit drain);
		lane_op_t op;
		op.kind = kind;
		op.a = a;
		op.b = b;
		op.m = m;
		op.drain = drain;
		ops_to_send.push_back(op);
	endtask

	// Mostly well-formed residues below a random modulus, some raw noise
	task automatic push_random_op(bit drain);
		logic [2:0] kind;
		logic [RB-1:0] a, m;
		logic [OPB_W-1:0] b;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			m = RB'($urandom_range(0, 1));
		else if (pick < 15)
			m = RB'($urandom_range(2, 40));
		else if (pick < 22)
			m = $urandom_range(0, 1) ? RES_MAX : BIG_PRIME;
		else
			m = RB'($urandom_range(2, RES_MAX));
		kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
			: 3'($urandom_range(0, 5));
		if (m != 0 && $urandom_range(0, 99) < 85)
			a = RB'($urandom % m);
		else
			a = RB'($urandom);
		pick = $urandom_range(0, 99);
		if (kind == rrma_pkg::KIND_SUBI || kind == rrma_pkg::KIND_SET) begin
			if (pick < 50)
				b = OPB_W'($urandom);
			else if (pick < 80 && m != 0)
				b = OPB_W'($urandom % m);
			else
				b = OPB_MAX - OPB_W'($urandom_range(0, 3));
		end else if (m != 0 && pick < 85) begin
			b = OPB_W'($urandom % m);
		end else begin
			b = OPB_W'($urandom);
		end
		push_op(kind, a, b, m, drain);
	endtask

	// Stimulus and end of run
	initial begin
		// corners: extremes, each operation, wrap-arounds, moduli zero and one
		push_op(rrma_pkg::KIND_ADD, 24'd0, 31'd0, 24'd2, 1'b0);
		push_op(rrma_pkg::KIND_ADD, BIG_PRIME - 1, 31'(BIG_PRIME - 1), BIG_PRIME, 1'b0);
		push_op(rrma_pkg::KIND_ADD, 24'd1, 31'd1, 24'd2, 1'b0);
		push_op(rrma_pkg::KIND_SUB, 24'd0, 31'(BIG_PRIME - 1), BIG_PRIME, 1'b0);
		push_op(rrma_pkg::KIND_SUB, 24'd3, 31'd5, 24'd7, 1'b0);
		push_op(rrma_pkg::KIND_SUB, 24'd5, 31'd5, 24'd7, 1'b0);
		push_op(rrma_pkg::KIND_MUL, BIG_PRIME - 1, 31'(BIG_PRIME - 1), BIG_PRIME, 1'b0);
		push_op(rrma_pkg::KIND_MUL, RES_MAX, OPB_MAX, BIG_PRIME, 1'b0);
		push_op(rrma_pkg::KIND_MUL, RES_MAX - 1, 31'(RES_MAX - 1), RES_MAX, 1'b0);
		push_op(rrma_pkg::KIND_DEC, 24'd0, OPB_MAX, BIG_PRIME, 1'b0);
		push_op(rrma_pkg::KIND_DEC, 24'd5, 31'd0, 24'd7, 1'b0);
		push_op(rrma_pkg::KIND_DEC, 24'd0, 31'd0, 24'd1, 1'b0);
		push_op(rrma_pkg::KIND_SUBI, 24'd3, OPB_MAX, BIG_PRIME, 1'b0);
		push_op(rrma_pkg::KIND_SUBI, 24'd100, 31'd40, 24'd101, 1'b0);
		push_op(rrma_pkg::KIND_SET, 24'd0, OPB_MAX, BIG_PRIME, 1'b0);
		push_op(rrma_pkg::KIND_SET, RES_MAX, 31'h2AAAAAAA, RES_MAX, 1'b0);
		push_op(rrma_pkg::KIND_ADD, RES_MAX, OPB_MAX, 24'd0, 1'b0);
		push_op(rrma_pkg::KIND_MUL, RES_MAX, OPB_MAX, 24'd1, 1'b0);
		push_op(rrma_pkg::KIND_SET, 24'd0, OPB_MAX, 24'd0, 1'b0);
		push_op(KIND_SPARE6, RES_MAX, 31'd7, BIG_PRIME, 1'b0);
		push_op(KIND_SPARE7, 24'h555555, 31'h2AAAAAAA, 24'hAAAAAA, 1'b0);
		push_op(rrma_pkg::KIND_ADD, 24'hAAAAAA, 31'h55555555, RES_MAX, 1'b0);
		push_op(rrma_pkg::KIND_SUB, 24'h555555, 31'h2AAAAAAA, 24'hAAAAAA, 1'b0);
		// random part; now and then wait for the pipeline to empty first
		for (int i = 0; i < RANDOM_ITEMS; i++)
			push_random_op(i % 250 == 0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (ops_to_send.size() != 0 || s_tvalid || results_seen != items_sent)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (error_count == 0 && predicted_residues.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Sender: bursts of items separated by random gaps
	always @(posedge clk) begin : drive_items
		lane_op_t op;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predicted_residues.push_back(driven_residue);
				items_sent++;
			end
			if (!(s_tvalid && !s_tready)) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (ops_to_send.size() != 0
						&& !(ops_to_send[0].drain && results_seen != items_sent)) begin
					op = ops_to_send.pop_front();
					driven_residue = lane_residue(op);
					s_tdata <= SDW'({op.m, op.b, op.a});
					s_tuser <= op.kind;
					s_tvalid <= 1'b1;
					if (burst_left == 0) begin
						burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
							: $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left--;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall pattern that switches between a few modes
	always @(posedge clk) begin : stall_results
		if (arst_n) begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 300);
				stall_phase = 0;
			end else begin
				mode_left--;
			end
			stall_phase++;
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (stall_phase % 16) >= 5;
			endcase
		end
	end

	// Compare each result with the oldest prediction
	always @(posedge clk) begin : check_results
		logic [RB-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
			if (predicted_residues.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("%0t: result %h with no item outstanding", $realtime, m_tdata);
			end else begin
				want = predicted_residues.pop_front();
				if (m_tdata !== MDW'(want)) begin
					error_count++;
					if (error_count <= 10)
						$display("%0t: result mismatch, expected %h, got %h",
							$realtime, MDW'(want), m_tdata);
				end
			end
		end
	end

	// Watchdog: too long without any item moving on either side
	always @(posedge clk) begin : watchdog
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule
